FILE: design/mpt_pkg.sv
// ============================================================================
// mpt_pkg - shared types and constants of the mount point table
// Field widths, operation codes, table entry and command structures.
// ============================================================================
`default_nettype none

package mpt_pkg;

    localparam int unsigned MODE_W      = 2;
    localparam int unsigned PARENT_W    = 5;
    localparam int unsigned INODE_W     = 32;
    localparam int unsigned IDX_FIELD_W = 4;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned SCAN_CHUNK  = 8;
    localparam int unsigned IDX_SPAN    = 16;

    localparam logic [PARENT_W-1:0] NO_PARENT = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_RANGE     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_WRITE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_HOLD = 2'd2
    } fsm_t;

    typedef struct packed {
        logic signed [PARENT_W-1:0] parent;
        logic [INODE_W-1:0]         inode;
        logic [INODE_W-1:0]         pinode;
    } entry_t;

    localparam entry_t CLEAR_ENTRY = '{parent: NO_PARENT, inode: '0, pinode: '0};

    // Command broadcast to every cell
    typedef struct packed {
        op_t                    op;
        logic [IDX_FIELD_W-1:0] idx;
        entry_t                 data;
        logic [CNT_W-1:0]       count;
        logic                   look_ok;
    } cmd_t;

    typedef struct packed {
        status_t                    status;
        logic [IDX_FIELD_W-1:0]     child;
        logic signed [PARENT_W-1:0] parent;
        logic [INODE_W-1:0]         inode;
        logic [INODE_W-1:0]         pinode;
    } result_t;

endpackage

`default_nettype wire

FILE: design/mpt_cell.sv
// ============================================================================
// mpt_cell - one table entry
// Holds one entry, compares it for lookups and hands its compacted value
// to the lower neighbor on a remove.
// ============================================================================
`default_nettype none

module mpt_cell
    import mpt_pkg::*;
#(
    parameter int unsigned CELL_ID = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire entry_t up_entry,
    output entry_t      entry,
    output entry_t      shift_entry,
    output logic        match
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   is_child;
    logic   is_above;

    // Orphan children of the removed entry, renumber parents above it
    always_comb
    begin
        is_child = (entry_reg.parent == $signed({1'b0, cmd.idx}));
        is_above = (entry_reg.parent > $signed({1'b0, cmd.idx}));
        shift_entry = entry_reg;
        if (is_child)
        begin
            shift_entry = CLEAR_ENTRY;
        end
        else if (is_above)
        begin
            shift_entry.parent = entry_reg.parent - 5'sd1;
        end
    end

    assign match = cmd.look_ok && (CELL_ID < 32'(cmd.count))
                && (entry_reg.parent == cmd.data.parent)
                && (entry_reg.inode == cmd.data.inode);

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_WRITE:
            begin
                if (32'(cmd.idx) == CELL_ID)
                begin
                    entry_next = cmd.data;
                end
            end
            OP_REMOVE:
            begin
                if (CELL_ID < 32'(cmd.idx))
                begin
                    entry_next = shift_entry;
                end
                else if (CELL_ID + 1 < 32'(cmd.count))
                begin
                    entry_next = up_entry;
                end
                else if (CELL_ID + 1 == 32'(cmd.count))
                begin
                    entry_next = CLEAR_ENTRY;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= CLEAR_ENTRY;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: design/mpt_scan.sv
// ============================================================================
// mpt_scan - first-match scanner
// Captures the match flags of all cells and walks them a chunk per cycle,
// lowest entry first.
// ============================================================================
`default_nettype none

module mpt_scan
    import mpt_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DEPTH-1:0]  match_vec,
    output logic                   done,
    output logic                   found,
    output logic [IDX_FIELD_W-1:0] child
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CHUNK = (DEPTH < SCAN_CHUNK) ? DEPTH : SCAN_CHUNK;

    logic [DEPTH-1:0]             scan_reg;
    logic [DEPTH-1:0]             scan_next;
    logic [IDX_W-1:0]             base_reg;
    logic [IDX_W-1:0]             base_next;
    logic [IDX_W-1:0]             offset;
    logic [IDX_W-1:0]             hit_index;
    logic [IDX_W+IDX_FIELD_W-1:0] hit_wide;
    logic                         rest_zero;

    // Lowest set flag in the current chunk
    always_comb
    begin
        offset = '0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (scan_reg[i])
            begin
                offset = IDX_W'(i);
            end
        end
    end

    assign found     = |scan_reg[CHUNK-1:0];
    assign rest_zero = ((scan_reg >> CHUNK) == '0);
    assign done      = found || rest_zero;
    assign hit_index = base_reg + offset;
    assign hit_wide  = {{IDX_FIELD_W{1'b0}}, hit_index};
    assign child     = hit_wide[IDX_FIELD_W-1:0];

    assign scan_next = start ? match_vec : (scan_reg >> CHUNK);
    assign base_next = start ? '0 : base_reg + IDX_W'(CHUNK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            base_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mount_point_table.sv
// ============================================================================
// mount_point_table - table of mount entries with lookup and compaction
// A row of entry cells; lookups scan for the lowest match, removes compact
// the table by shifting the cells above the removed entry down by one.
// ============================================================================
//
//  channel   | direction | beat content
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one request: mode, parent_disk, inode,
//            |           | parent_inode, index
//  m_axis    | out       | one response per request: status, child_index,
//            |           | entry_parent, entry_inode, entry_parent_inode
//  cfg       | in        | entries_in_use (5 bits)
//
// Remove, write and read results are registered at the edge that accepts
// the request. A lookup first captures the match flags; the scanner then
// walks them eight cells a cycle and stops at the first hit or when no
// flags are left. A new request is taken as soon as the previous result
// has moved into the output register.
// Reset clears every entry to no parent, zero inodes; entries_in_use = 16.
// A stalled output keeps its beat; a finished result waits in the hold
// register and the input stays not ready until the output frees up.
// ============================================================================
`default_nettype none

module mount_point_table
    import mpt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] mode, [6:2] parent_disk, [38:7] inode, [70:39] parent_inode,
    // [74:71] index, [79:75] zero
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [5:2] child_index, [10:6] entry_parent,
    // [42:11] entry_inode, [74:43] entry_parent_inode, [79:75] zero
    output logic [79:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    mode_t                      req_mode;
    logic signed [PARENT_W-1:0] req_parent;
    logic [INODE_W-1:0]         req_inode;
    logic [INODE_W-1:0]         req_pinode;
    logic [IDX_FIELD_W-1:0]     req_idx;

    assign req_mode   = mode_t'(s_axis_tdata[1:0]);
    assign req_parent = s_axis_tdata[6:2];
    assign req_inode  = s_axis_tdata[38:7];
    assign req_pinode = s_axis_tdata[70:39];
    assign req_idx    = s_axis_tdata[74:71];

    // ------------------------------------------------------------------
    // Configuration: count of entries in use, saturated to the depth
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] active_count;

    assign cfg_ready  = 1'b1;
    assign count_next = (cfg_valid && cfg_ready) ? cfg_data : count_reg;
    assign active_count = (32'(count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_reg;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    fsm_t    state_reg;
    fsm_t    state_next;
    logic    in_fire;
    logic    out_free;
    logic    done_now;
    logic    load_out;
    logic    load_hold;
    logic    scan_done;
    logic    scan_found;
    logic [IDX_FIELD_W-1:0] scan_child;
    result_t res_now;
    result_t acc_res;
    result_t scan_res;
    result_t hold_reg;
    result_t hold_next;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    cmd_t    cmd;
    logic    remove_range;
    logic    slot_range;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign remove_range = (32'(req_idx) >= 32'(active_count));
    assign slot_range   = (32'(req_idx) >= TABLE_DEPTH);

    // Broadcast to the cells; only legal modifying requests touch the table
    always_comb
    begin
        cmd.op          = OP_NONE;
        cmd.idx         = req_idx;
        cmd.data.parent = req_parent;
        cmd.data.inode  = req_inode;
        cmd.data.pinode = req_pinode;
        cmd.count       = active_count;
        cmd.look_ok     = (active_count != '0) && (req_inode != '0) && !req_parent[PARENT_W-1];
        if (in_fire)
        begin
            if (req_mode == MODE_REMOVE && !remove_range)
            begin
                cmd.op = OP_REMOVE;
            end
            else if (req_mode == MODE_WRITE && !slot_range)
            begin
                cmd.op = OP_WRITE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Chain of cells
    // ------------------------------------------------------------------
    entry_t             cell_entry [TABLE_DEPTH];
    entry_t             cell_shift [TABLE_DEPTH];
    entry_t             cell_up    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    entry_t             rd_tab     [IDX_SPAN];

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign cell_up[g] = CLEAR_ENTRY;
        end
        else
        begin : g_mid
            assign cell_up[g] = cell_shift[g+1];
        end

        mpt_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .up_entry    (cell_up[g]),
            .entry       (cell_entry[g]),
            .shift_entry (cell_shift[g]),
            .match       (match_vec[g])
        );
    end

    // Read port: only the first sixteen cells are addressable
    for (genvar k = 0; k < IDX_SPAN; k++)
    begin : g_rd
        if (k < TABLE_DEPTH)
        begin : g_on
            assign rd_tab[k] = cell_entry[k];
        end
        else
        begin : g_off
            assign rd_tab[k] = CLEAR_ENTRY;
        end
    end

    mpt_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire && req_mode == MODE_LOOKUP),
        .match_vec (match_vec),
        .done      (scan_done),
        .found     (scan_found),
        .child     (scan_child)
    );

    // ------------------------------------------------------------------
    // Results
    // ------------------------------------------------------------------
    always_comb
    begin
        acc_res.status = STAT_DONE;
        acc_res.child  = '0;
        acc_res.parent = NO_PARENT;
        acc_res.inode  = '0;
        acc_res.pinode = '0;
        case (req_mode)
            MODE_REMOVE:
            begin
                if (remove_range)
                begin
                    acc_res.status = STAT_RANGE;
                end
            end
            MODE_WRITE:
            begin
                if (slot_range)
                begin
                    acc_res.status = STAT_RANGE;
                end
            end
            MODE_READ:
            begin
                if (slot_range)
                begin
                    acc_res.status = STAT_RANGE;
                end
                else
                begin
                    acc_res.parent = rd_tab[req_idx].parent;
                    acc_res.inode  = rd_tab[req_idx].inode;
                    acc_res.pinode = rd_tab[req_idx].pinode;
                end
            end
            default:
            begin
                acc_res.status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        scan_res.status = scan_found ? STAT_DONE : STAT_NOT_FOUND;
        scan_res.child  = scan_found ? scan_child : '0;
        scan_res.parent = NO_PARENT;
        scan_res.inode  = '0;
        scan_res.pinode = '0;
    end

    assign res_now  = (state_reg == S_SCAN) ? scan_res : acc_res;
    assign done_now = (state_reg == S_IDLE && in_fire && req_mode != MODE_LOOKUP)
                   || (state_reg == S_SCAN && scan_done);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_mode == MODE_LOOKUP)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (!out_free)
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and hold registers
    always_comb
    begin
        load_out  = (done_now && out_free) || (state_reg == S_HOLD && out_free);
        load_hold = done_now && !out_free;
        hold_next = load_hold ? res_now : hold_reg;
        out_next  = out_reg;
        if (load_out)
        begin
            out_next = (state_reg == S_HOLD) ? hold_reg : res_now;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= CNT_W'(IDX_SPAN);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.pinode, out_reg.inode, out_reg.parent,
                            out_reg.child, out_reg.status};

`ifndef SYNTHESIS
    // A held result always means the output register is occupied
    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HOLD |-> out_valid_reg)
        else $error("hold state with empty output register");

    // An accepted lookup always enters the scan
    a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req_mode == MODE_LOOKUP) |=> state_reg == S_SCAN)
        else $error("lookup did not start a scan");

    // A scan finishing into a stalled output parks its result
    a_scan_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_done && !out_free) |=> state_reg == S_HOLD)
        else $error("scan result lost on stalled output");

    // Table changes only on the edge that accepts a request
    a_cmd_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op != OP_NONE |-> in_fire)
        else $error("table command without an accepted beat");
`endif

endmodule

`default_nettype wire

FILE: verif/mount_point_table_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// mount_point_table_checker - response predictor and scoreboard
// Tracks the table contents and the in-use count from the accepted request
// and config beats, queues the predicted response for each request and
// compares every accepted response beat against the oldest prediction.
// ============================================================================

module mount_point_table_checker
    import mpt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [4:0]  cfg_data,
    output logic [31:0]      fail_count,
    output logic [31:0]      pending
);

    logic signed [PARENT_W-1:0] parent_mem [TABLE_DEPTH];
    logic [INODE_W-1:0]         inode_mem  [TABLE_DEPTH];
    logic [INODE_W-1:0]         pinode_mem [TABLE_DEPTH];
    logic [CNT_W-1:0]           in_use;
    result_t                    response_q [$];
    int                         response_no;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: response %0d %s: got %0h, want %0h",
                 $time, response_no, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic clear_slot(input int slot);
        parent_mem[slot] = NO_PARENT;
        inode_mem[slot]  = '0;
        pinode_mem[slot] = '0;
    endtask

    // Update the table for one request and return the response it earns
    task automatic apply_request(input logic [79:0] beat, output result_t res);
        mode_t                      op;
        logic signed [PARENT_W-1:0] pdisk;
        logic [INODE_W-1:0]         ino;
        logic [INODE_W-1:0]         pino;
        int                         ix;
        int                         n;
        int                         p;
        bit                         hit;
        op    = mode_t'(beat[1:0]);
        pdisk = beat[6:2];
        ino   = beat[38:7];
        pino  = beat[70:39];
        ix    = int'(beat[74:71]);
        n     = (int'(in_use) > int'(TABLE_DEPTH)) ? int'(TABLE_DEPTH) : int'(in_use);
        hit   = 1'b0;
        res   = '{status: STAT_DONE, child: '0, parent: NO_PARENT,
                  inode: '0, pinode: '0};
        case (op)
            MODE_LOOKUP:
            begin
                res.status = STAT_NOT_FOUND;
                if (n != 0 && ino != 0 && pdisk >= 0)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (!hit && parent_mem[i] == pdisk && inode_mem[i] == ino)
                        begin
                            hit        = 1'b1;
                            res.status = STAT_DONE;
                            res.child  = i[IDX_FIELD_W-1:0];
                        end
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (ix >= n)
                    res.status = STAT_RANGE;
                else
                begin
                    // orphan children, renumber parents above the hole
                    for (int i = 0; i < n; i++)
                    begin
                        p = int'(parent_mem[i]);
                        if (i != ix)
                        begin
                            if (p == ix)
                                clear_slot(i);
                            else if (p > ix)
                                parent_mem[i] = parent_mem[i] - 5'sd1;
                        end
                    end
                    for (int i = ix; i + 1 < n; i++)
                    begin
                        parent_mem[i] = parent_mem[i + 1];
                        inode_mem[i]  = inode_mem[i + 1];
                        pinode_mem[i] = pinode_mem[i + 1];
                    end
                    clear_slot(n - 1);
                end
            end
            MODE_WRITE:
            begin
                if (ix >= TABLE_DEPTH)
                    res.status = STAT_RANGE;
                else
                begin
                    parent_mem[ix] = pdisk;
                    inode_mem[ix]  = ino;
                    pinode_mem[ix] = pino;
                end
            end
            default:
            begin
                if (ix >= TABLE_DEPTH)
                    res.status = STAT_RANGE;
                else
                begin
                    res.parent = parent_mem[ix];
                    res.inode  = inode_mem[ix];
                    res.pinode = pinode_mem[ix];
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t next;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                clear_slot(i);
            in_use      = 5'd16;
            response_q.delete();
            response_no = 0;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // responses first: a response can never belong to a request
            // accepted at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (response_q.size() == 0)
                    flag_mismatch("arrived with nothing expected", m_axis_tdata[31:0], 0);
                else
                begin
                    want = response_q.pop_front();
                    if (m_axis_tdata[1:0] != want.status)
                        flag_mismatch("status", 32'(m_axis_tdata[1:0]),
                                      32'(want.status));
                    if (m_axis_tdata[5:2] != want.child)
                        flag_mismatch("child_index", 32'(m_axis_tdata[5:2]),
                                      32'(want.child));
                    if (m_axis_tdata[10:6] != want.parent)
                        flag_mismatch("entry_parent", 32'(m_axis_tdata[10:6]),
                                      {27'd0, want.parent});
                    if (m_axis_tdata[42:11] != want.inode)
                        flag_mismatch("entry_inode", m_axis_tdata[42:11], want.inode);
                    if (m_axis_tdata[74:43] != want.pinode)
                        flag_mismatch("entry_parent_inode", m_axis_tdata[74:43],
                                      want.pinode);
                end
                response_no = response_no + 1;
            end
            if (cfg_valid && cfg_ready)
                in_use = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(s_axis_tdata, next);
                response_q.push_back(next);
            end
            pending = response_q.size();
        end
    end

endmodule

FILE: verif/mount_point_table_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// mount_point_table_tb - stimulus and verdict for the mount point table
// Drives a directed set of lookups, writes, reads and removes that hit the
// range edges and the orphan/renumber paths of a remove, then random
// traffic over several in-use counts, with random gaps on both streams.
// The checker beside the block predicts and scores every response.
// ============================================================================

module mount_point_table_tb;
    import mpt_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int          STALL_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 175;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [1:0] mode, [6:2] parent_disk, [38:7] inode, [70:39] parent_inode,
    // [74:71] index, [79:75] zero
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [5:2] child_index, [10:6] entry_parent,
    // [42:11] entry_inode, [74:43] entry_parent_inode, [79:75] zero
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    logic [31:0] fail_count;
    logic [31:0] pending;
    bit          calm = 1'b0;    // set to suppress idling on both sides
    int          active_n = 16;  // in-use count as the block sees it
    int          idle_cycles = 0;

    mount_point_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    mount_point_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Response side: stall about 12 percent of the time, never while calm
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 12);

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request beat and hold it until accepted. Enter and leave at
    // a rising edge; tvalid stays high on exit so back-to-back beats never
    // see a low/high pair in the same step.
    task automatic send_request(input mode_t m, input logic [4:0] pd,
                                input logic [31:0] ino, input logic [31:0] pino,
                                input logic [3:0] ix);
        bit hit;
        if (!calm && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, ix, pino, ino, pd, m};
        // sample tready mid-cycle, where it is settled, then take the edge
        do
        begin
            @(negedge clk);
            hit = s_axis_tready;
            @(posedge clk);
        end
        while (!hit);
    endtask

    // Write entries_in_use with the table idle: drop the request stream,
    // drain every outstanding response, allow for lookup latency, then write.
    task automatic set_entries_in_use(input logic [4:0] value);
        bit hit;
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        while (!hit);
        cfg_valid <= 1'b0;
        active_n = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    initial
    begin
        mode_t       m;
        logic [4:0]  pd;
        logic [31:0] ino;
        logic [31:0] pino;
        logic [3:0]  ix;
        logic [4:0]  count_sel;
        int          roll;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed: reset contents, in-use count at its reset value ----
        send_request(MODE_READ,   5'h1f, 32'h0, 32'h0, 4'd0);
        send_request(MODE_READ,   5'h1f, 32'h0, 32'h0, 4'd15);
        // zero inode is never found
        send_request(MODE_LOOKUP, 5'd0,  32'h0, 32'h0, 4'd0);
        // load a small tree, extremes of every field included
        send_request(MODE_WRITE,  5'h1f, 32'hffff_ffff, 32'hffff_ffff, 4'd0);
        send_request(MODE_WRITE,  5'd0,  32'd5, 32'ha5a5_a5a5, 4'd1);
        send_request(MODE_WRITE,  5'd1,  32'd7, 32'd1, 4'd2);
        send_request(MODE_WRITE,  5'd0,  32'd5, 32'h5a5a_5a5a, 4'd3);
        send_request(MODE_WRITE,  5'd15, 32'hffff_ffff, 32'h0, 4'd15);
        // parent of -16 is stored as given
        send_request(MODE_WRITE,  5'h10, 32'd9, 32'h8000_0001, 4'd4);
        // negative parent is never found, even with a stored match
        send_request(MODE_LOOKUP, 5'h1f, 32'hffff_ffff, 32'h0, 4'd0);
        // duplicate key: the lowest entry wins
        send_request(MODE_LOOKUP, 5'd0,  32'd5, 32'h0, 4'd0);
        send_request(MODE_LOOKUP, 5'd1,  32'd7, 32'h0, 4'd0);
        send_request(MODE_LOOKUP, 5'd15, 32'hffff_ffff, 32'h0, 4'd0);
        send_request(MODE_LOOKUP, 5'd3,  32'd5, 32'h0, 4'd0);
        send_request(MODE_READ,   5'd0,  32'h0, 32'h0, 4'd4);
        // remove with a child to orphan and a parent above to renumber
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd1);
        send_request(MODE_READ,   5'd0,  32'h0, 32'h0, 4'd1);
        send_request(MODE_READ,   5'd0,  32'h0, 32'h0, 4'd14);
        send_request(MODE_READ,   5'd0,  32'h0, 32'h0, 4'd15);
        // remove the last in-use entry
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd15);

        // empty table view: lookup not found, any remove out of range
        set_entries_in_use(5'd0);
        send_request(MODE_LOOKUP, 5'd0,  32'd5, 32'h0, 4'd0);
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd0);
        // oversized count saturates to the table depth
        set_entries_in_use(5'd31);
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd15);
        send_request(MODE_READ,   5'd0,  32'h0, 32'h0, 4'd14);
        // single entry in use
        set_entries_in_use(5'd1);
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd1);
        send_request(MODE_REMOVE, 5'd0,  32'h0, 32'h0, 4'd0);

        // ---- random phases, each with its own in-use count ----
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count_sel = 5'd16;
                1:       count_sel = 5'd31;
                2:       count_sel = 5'd9;
                3:       count_sel = 5'd2;
                4:       count_sel = 5'd0;
                5:       count_sel = 5'd16;
                6:       count_sel = 5'd5;
                7:       count_sel = 5'd1;
                default: count_sel = 5'($urandom_range(31));
            endcase
            set_entries_in_use(count_sel);
            calm = (p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // small key pools make lookups hit the entries written
                roll = $urandom_range(99);
                if (roll < 35)
                    m = MODE_LOOKUP;
                else if (roll < 70)
                    m = MODE_WRITE;
                else if (roll < 82)
                    m = MODE_REMOVE;
                else
                    m = MODE_READ;
                roll = $urandom_range(99);
                if (roll < 12)
                    pd = 5'h1f;
                else if (roll < 80)
                    pd = 5'($urandom_range(4));
                else
                    pd = 5'($urandom_range(31));
                roll = $urandom_range(99);
                if (roll < 6)
                    ino = 32'h0;
                else if (roll < 78)
                    ino = $urandom_range(1, 6);
                else
                    ino = $urandom;
                pino = ($urandom_range(99) < 50) ? $urandom_range(1, 6) : $urandom;
                // removes mostly target an in-use slot
                if (m == MODE_REMOVE && active_n != 0 && $urandom_range(99) < 75)
                    ix = 4'($urandom_range(active_n - 1));
                else
                    ix = 4'($urandom_range(15));
                send_request(m, pd, ino, pino, ix);
            end
        end
        calm = 1'b0;

        // ---- drain and give the verdict ----
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
